FILE: hw/rtl/apb_pkg.sv
// Shared types, constants and codes for the audio ping-pong buffer.
package apb_pkg;

	// Store geometry: two halves of HALF_WORDS samples each
	localparam int HALF_WORDS = 256;
	localparam int STORE_WORDS = 2 * HALF_WORDS;
	localparam int POS_W = $clog2(HALF_WORDS);
	localparam int ADDR_W = $clog2(STORE_WORDS);
	localparam int SAMPLE_W = 16;
	localparam int BYTE_W = 8;
	localparam int LIMIT_W = 16;
	localparam logic [LIMIT_W-1:0] SILENCE_RESET = 16'd5000;

	// Result queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Command codes
	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_IDLE   = 2'd1,
		CMD_DRAIN  = 2'd2
	} cmd_t;

	// Status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_UNDERRUN = 2'd2
	} status_t;

	// Result fields known at the front, before the store read returns
	typedef struct packed {
		status_t status;
		logic    word_valid;
		logic    last_of_half;
		logic    muted;
		logic    half_a_full;
		logic    half_b_full;
	} meta_t;

	// One front-to-back transaction
	typedef struct packed {
		logic  valid;
		meta_t meta;
	} front_out_t;

	// One complete result
	typedef struct packed {
		meta_t               meta;
		logic [SAMPLE_W-1:0] word_out;
	} result_t;

endpackage

FILE: hw/rtl/apb_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module apb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/apb_front.sv
// Front end: accepts commands, keeps buffer control state, drives store ports.
module apb_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [apb_pkg::LIMIT_W-1:0]        cfg_wdata,
	input  logic                               accept,
	input  logic [1:0]                         cmd,
	input  logic [apb_pkg::BYTE_W-1:0]         sample_hi,
	input  logic [apb_pkg::BYTE_W-1:0]         sample_lo,
	input  logic                               first_of_packet,
	output logic                               ram_we,
	output logic [apb_pkg::ADDR_W-1:0]         ram_waddr,
	output logic [apb_pkg::SAMPLE_W-1:0]       ram_wdata,
	output logic                               ram_re,
	output logic [apb_pkg::ADDR_W-1:0]         ram_raddr,
	output apb_pkg::front_out_t                fout
);

	logic                         wsel_q, wsel_d;
	logic [apb_pkg::POS_W-1:0]    wpos_q, wpos_d;
	logic [1:0]                   ready_q, ready_d;
	logic                         drop_q, drop_d;
	logic                         drain_q, drain_d;
	logic                         rsel_q, rsel_d;
	logic [apb_pkg::POS_W-1:0]    rpos_q, rpos_d;
	logic [apb_pkg::LIMIT_W-1:0]  idle_q, idle_d;
	logic                         mute_q, mute_d;
	logic [apb_pkg::LIMIT_W-1:0]  limit_q;
	logic [apb_pkg::LIMIT_W-1:0]  idle_inc;
	apb_pkg::meta_t               meta;

	localparam logic [apb_pkg::POS_W-1:0] POS_LAST = apb_pkg::POS_W'(apb_pkg::HALF_WORDS - 1);

	assign idle_inc = idle_q + apb_pkg::LIMIT_W'(1);

	// Next-state and store access for the accepted command
	always_comb begin
		wsel_d    = wsel_q;
		wpos_d    = wpos_q;
		ready_d   = ready_q;
		drop_d    = drop_q;
		drain_d   = drain_q;
		rsel_d    = rsel_q;
		rpos_d    = rpos_q;
		idle_d    = idle_q;
		mute_d    = mute_q;
		ram_we    = 1'b0;
		ram_waddr = {wsel_q, wpos_q};
		ram_wdata = {sample_hi, sample_lo};
		ram_re    = 1'b0;
		ram_raddr = {rsel_q, rpos_q};
		meta      = '0;
		meta.status = apb_pkg::ST_OK;
		if (accept) begin
			unique case (cmd)
				apb_pkg::CMD_SAMPLE: begin
					if (first_of_packet) begin
						mute_d = 1'b0;
						drop_d = ready_q[0] && ready_q[1];
					end
					if (!drop_d && ready_q[wsel_q]) begin
						drop_d = 1'b1;
					end
					if (drop_d) begin
						meta.status = apb_pkg::ST_OVERFLOW;
					end else begin
						ram_we = 1'b1;
						wpos_d = wpos_q + apb_pkg::POS_W'(1);
						if (wpos_q == POS_LAST) begin
							ready_d[wsel_q] = 1'b1;
							wsel_d = ~wsel_q;
							wpos_d = '0;
						end
					end
				end
				apb_pkg::CMD_IDLE: begin
					idle_d = idle_inc;
					if (idle_inc >= limit_q) begin
						mute_d = 1'b1;
						idle_d = '0;
					end
				end
				apb_pkg::CMD_DRAIN: begin
					if (!drain_q) begin
						if (ready_q[0]) begin
							drain_d = 1'b1;
							rsel_d  = 1'b0;
							rpos_d  = '0;
						end else if (ready_q[1]) begin
							drain_d = 1'b1;
							rsel_d  = 1'b1;
							rpos_d  = '0;
						end
					end
					if (!drain_d) begin
						meta.status = apb_pkg::ST_UNDERRUN;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = {rsel_d, rpos_d};
						meta.word_valid = 1'b1;
						if (rpos_d == POS_LAST) begin
							meta.last_of_half = 1'b1;
							ready_d[rsel_d] = 1'b0;
							drain_d = 1'b0;
							rpos_d  = '0;
						end else begin
							rpos_d = rpos_d + apb_pkg::POS_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
		meta.muted       = mute_d;
		meta.half_a_full = ready_d[0];
		meta.half_b_full = ready_d[1];
	end

	assign fout.valid = accept;
	assign fout.meta  = meta;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsel_q  <= 1'b0;
			wpos_q  <= '0;
			ready_q <= '0;
			drop_q  <= 1'b0;
			drain_q <= 1'b0;
			rsel_q  <= 1'b0;
			rpos_q  <= '0;
			idle_q  <= '0;
			mute_q  <= 1'b0;
		end else begin
			wsel_q  <= wsel_d;
			wpos_q  <= wpos_d;
			ready_q <= ready_d;
			drop_q  <= drop_d;
			drain_q <= drain_d;
			rsel_q  <= rsel_d;
			rpos_q  <= rpos_d;
			idle_q  <= idle_d;
			mute_q  <= mute_d;
		end
	end

	// Silence limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= apb_pkg::SILENCE_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

endmodule

FILE: hw/rtl/apb_back.sv
// Back end: joins store read data with front results and queues them for output.
module apb_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  apb_pkg::front_out_t           fout,
	input  logic [apb_pkg::SAMPLE_W-1:0]  ram_rdata,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output apb_pkg::result_t              out_result
);

	logic                          v_s1;
	apb_pkg::meta_t                meta_s1;
	apb_pkg::result_t              queue_q [apb_pkg::QDEPTH];
	logic [apb_pkg::QPTR_W-1:0]    wptr_q;
	logic [apb_pkg::QPTR_W-1:0]    rptr_q;
	logic [apb_pkg::QCNT_W-1:0]    count_q;
	logic                          push;
	logic                          pop;
	apb_pkg::result_t              push_data;

	// Stage register waiting for the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= fout.valid;
		end
	end

	always_ff @(posedge clk) begin
		meta_s1 <= fout.meta;
	end

	// Complete result; word is zero unless a drain delivered one
	always_comb begin
		push_data.meta     = meta_s1;
		push_data.word_out = meta_s1.word_valid ? ram_rdata : '0;
	end

	assign push      = v_s1;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_result = queue_q[rptr_q];

	// Room for the item in flight plus a new one
	assign in_ready = (({1'b0, count_q} + (apb_pkg::QCNT_W + 1)'(v_s1))
		< (apb_pkg::QCNT_W + 1)'(apb_pkg::QDEPTH));

	// Result queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wptr_q] <= push_data;
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + apb_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + apb_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + apb_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - apb_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/audio_ping_pong_buffer_unit.sv
// Top level of the audio ping-pong buffer: stream ports, store and front/back.
//
// Double-buffered audio store with two halves of 256 sample words. One command is
// accepted per clock cycle while ready is high; each produces exactly one result,
// which passes the stage register and result queue to the output stream. The rate
// is set by the sample store, a RAM with one write and one read port: a sample
// write and a drain read both complete in the accepting cycle, the read data is
// registered. A four-entry result queue decouples the input from output stalls;
// input ready drops only when that queue and the item in flight fill it. The store
// needs no clearing after reset: only fully written halves are ever drained.
module audio_ping_pong_buffer_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: silence_limit
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	// Command stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] sample_hi, [15:8] sample_lo
	input  logic [2:0]  s_axis_tuser,  // [1:0] cmd, [2] first_of_packet
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // [15:0] word_out, [16] muted, [17] half_a_full,
	                                   // [18] half_b_full, [23:19] zero
	output logic [2:0]  m_axis_tuser,  // [1:0] status, [2] word_valid
	output logic        m_axis_tlast   // last_of_half
);

	logic                          accept;
	logic                          ram_we;
	logic [apb_pkg::ADDR_W-1:0]    ram_waddr;
	logic [apb_pkg::SAMPLE_W-1:0]  ram_wdata;
	logic                          ram_re;
	logic [apb_pkg::ADDR_W-1:0]    ram_raddr;
	logic [apb_pkg::SAMPLE_W-1:0]  ram_rdata;
	apb_pkg::front_out_t           fout;
	apb_pkg::result_t              res;

	// Input transaction
	assign accept = s_axis_tvalid && s_axis_tready;

	apb_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.accept          (accept),
		.cmd             (s_axis_tuser[1:0]),
		.sample_hi       (s_axis_tdata[7:0]),
		.sample_lo       (s_axis_tdata[15:8]),
		.first_of_packet (s_axis_tuser[2]),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_re          (ram_re),
		.ram_raddr       (ram_raddr),
		.fout            (fout)
	);

	apb_ram #(
		.WIDTH (apb_pkg::SAMPLE_W),
		.DEPTH (apb_pkg::STORE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	apb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fout       (fout),
		.ram_rdata  (ram_rdata),
		.in_ready   (s_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_result (res)
	);

	// Output packing
	assign m_axis_tdata = {5'd0, res.meta.half_b_full, res.meta.half_a_full,
		res.meta.muted, res.word_out};
	assign m_axis_tuser = {res.meta.word_valid, res.meta.status};
	assign m_axis_tlast = res.meta.last_of_half;

endmodule
